@@ sv/mpq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mpq_pkg;

	localparam int KEY_W = 32;
	localparam int TAG_W = 16;
	localparam int STATUS_W = 2;

	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t ST_OK = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL = 2'd2;

	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP = 1'b1;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} entry_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctrl_t;

endpackage

`default_nettype wire

@@ sv/mpq_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mpq_cell (
	input  wire logic                  clk,
	input  wire mpq_pkg::cell_ctrl_t   ctrl,
	input  wire mpq_pkg::entry_t       new_ent,
	input  wire logic                  valid,
	input  wire mpq_pkg::entry_t       left_ent,
	input  wire logic                  left_before,
	input  wire mpq_pkg::entry_t       right_ent,
	output mpq_pkg::entry_t            ent,
	output logic                       ahead
);

	mpq_pkg::entry_t ent_q;

	// new word lands ahead of this slot: slot empty or holds a strictly larger key
	assign ahead = !valid || (ent_q.key > new_ent.key);
	assign ent = ent_q;

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			if (left_before) begin
				ent_q <= left_ent;
			end else if (ahead) begin
				ent_q <= new_ent;
			end
		end else if (ctrl.pop) begin
			ent_q <= right_ent;
		end
	end

endmodule

`default_nettype wire

@@ sv/min_priority_queue.sv @@
// Sorted min-priority queue built as a chain of DEPTH compare-and-shift cells.
//
// Input channel (in_valid/in_ready): one word per operation. action 0 pushes
// (in_key, in_tag); action 1 pops the entry with the smallest key. Equal keys
// leave in push order.
// Output channel (out_valid/out_ready): exactly one result word per input word.
// A pop returns the key and tag with status ok, or key 0 / tag 0 with status
// empty. A push returns zeros with status ok, or status full if DEPTH entries
// are already held (the entry is dropped).
//
// The result is registered and shows in the cycle after acceptance.
// Throughput: one word per cycle while in_ready is high. Every cell compares its
// key against the broadcast key and shifts in the accepting clock, so the whole
// insert or removal finishes in that clock.
// Stalls: a single output register holds the result; in_ready drops while it
// is full and not being taken, and rises again in the cycle it is taken.
// Reset (arst_n low): queue becomes empty, output register invalid. Slot
// contents are not cleared; only slots below the fill count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module min_priority_queue #(
	parameter int DEPTH = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            action,
	input  wire logic signed [mpq_pkg::KEY_W-1:0] in_key,
	input  wire logic [mpq_pkg::TAG_W-1:0]        in_tag,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic signed [mpq_pkg::KEY_W-1:0]      out_key,
	output logic [mpq_pkg::TAG_W-1:0]             out_tag,
	output logic [mpq_pkg::STATUS_W-1:0]          status
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	// fill count
	logic [CNT_W-1:0] count_q;
	logic             full;
	logic             empty;

	// handshake and command decode
	logic                in_acc;
	logic                push_go;
	logic                pop_go;
	mpq_pkg::cell_ctrl_t ctrl;
	mpq_pkg::entry_t     new_ent;

	// chain wiring
	mpq_pkg::entry_t cell_ent [DEPTH];
	logic            cell_before [DEPTH];
	logic            cell_valid [DEPTH];
	mpq_pkg::entry_t left_ent [DEPTH];
	logic            left_before [DEPTH];
	mpq_pkg::entry_t right_ent [DEPTH];

	// result register
	logic                  out_valid_q;
	mpq_pkg::entry_t       res_ent_q;
	mpq_pkg::status_t      status_q;
	mpq_pkg::entry_t       res_ent;
	mpq_pkg::status_t      res_status;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	// output slot frees up in the same cycle it is taken
	assign in_ready = !out_valid_q || out_ready;
	assign in_acc = in_valid && in_ready;
	assign push_go = in_acc && (action == mpq_pkg::ACT_PUSH) && !full;
	assign pop_go = in_acc && (action == mpq_pkg::ACT_POP) && !empty;

	assign ctrl.push = push_go;
	assign ctrl.pop = pop_go;
	assign new_ent.key = in_key;
	assign new_ent.tag = in_tag;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			// slots below the fill count hold live entries
			assign cell_valid[gi] = (count_q > CNT_W'(gi));

			if (gi == 0) begin : g_head
				assign left_ent[gi] = '0;
				assign left_before[gi] = 1'b0;
			end else begin : g_mid
				assign left_ent[gi] = cell_ent[gi-1];
				assign left_before[gi] = cell_before[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_tail
				assign right_ent[gi] = '0;
			end else begin : g_body
				assign right_ent[gi] = cell_ent[gi+1];
			end

			mpq_cell u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.new_ent     (new_ent),
				.valid       (cell_valid[gi]),
				.left_ent    (left_ent[gi]),
				.left_before (left_before[gi]),
				.right_ent   (right_ent[gi]),
				.ent         (cell_ent[gi]),
				.ahead       (cell_before[gi])
			);
		end
	endgenerate

	// result word: head entry on a good pop, zeros otherwise
	always_comb begin
		res_ent = '0;
		res_status = mpq_pkg::ST_OK;
		if (action == mpq_pkg::ACT_POP) begin
			if (empty) begin
				res_status = mpq_pkg::ST_EMPTY;
			end else begin
				res_ent = cell_ent[0];
			end
		end else if (full) begin
			res_status = mpq_pkg::ST_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push_go) begin
			count_q <= count_q + CNT_W'(1);
		end else if (pop_go) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_ent_q <= res_ent;
			status_q <= res_status;
		end
	end

	assign out_valid = out_valid_q;
	assign out_key = res_ent_q.key;
	assign out_tag = res_ent_q.tag;
	assign status = status_q;

endmodule

`default_nettype wire

@@ sv/mpq_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mpq_checker #(
	parameter int DEPTH = 16
) (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             in_valid,
	input wire logic                             in_ready,
	input wire logic                             action,
	input wire logic                             out_valid,
	input wire logic                             out_ready,
	input wire logic signed [mpq_pkg::KEY_W-1:0] out_key,
	input wire logic [mpq_pkg::TAG_W-1:0]        out_tag,
	input wire logic [mpq_pkg::STATUS_W-1:0]     status
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic             in_acc;
	logic [CNT_W-1:0] shadow_q;
	logic             shadow_full;
	logic             shadow_empty;

	assign in_acc = in_valid && in_ready;
	assign shadow_full = (shadow_q == CNT_W'(DEPTH));
	assign shadow_empty = (shadow_q == '0);

	// occupancy as seen from the ports
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_q <= '0;
		end else if (in_acc) begin
			if (action == mpq_pkg::ACT_PUSH && !shadow_full) begin
				shadow_q <= shadow_q + CNT_W'(1);
			end else if (action == mpq_pkg::ACT_POP && !shadow_empty) begin
				shadow_q <= shadow_q - CNT_W'(1);
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_key) && $stable(out_tag)
			&& $stable(status))
		else $error("result word changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != mpq_pkg::ST_OK |-> out_key == '0 && out_tag == '0)
		else $error("error result carries nonzero payload");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && action == mpq_pkg::ACT_POP && shadow_empty
			|=> out_valid && status == mpq_pkg::ST_EMPTY)
		else $error("pop on empty queue not flagged");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && action == mpq_pkg::ACT_PUSH && shadow_full
			|=> out_valid && status == mpq_pkg::ST_FULL)
		else $error("push on full queue not flagged");

	a_ok: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && ((action == mpq_pkg::ACT_PUSH && !shadow_full)
			|| (action == mpq_pkg::ACT_POP && !shadow_empty))
			|=> out_valid && status == mpq_pkg::ST_OK)
		else $error("good operation not reported ok");

endmodule

bind min_priority_queue mpq_checker #(.DEPTH(DEPTH)) u_mpq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.action    (action),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_key   (out_key),
	.out_tag   (out_tag),
	.status    (status)
);

`default_nettype wire
